// ===== rtl/rtcbcd_pkg.sv =====
// Package for the RTC BCD time I2C sequencer: codes, field widths and the
// BCD and register-address helper functions.
// Depends on nothing; used by rtc_bcd_time_i2c_sequencer_top.
`default_nettype none

package rtcbcd_pkg;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 104;
  localparam int unsigned NumRegs  = 6;

  typedef enum logic [1:0] {
    CMD_POLL  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_SPARE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_ADDR  = 3'd1,
    ACT_READ  = 3'd2,
    ACT_WDATA = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    DONE_NONE  = 2'd0,
    DONE_READ  = 2'd1,
    DONE_WRITE = 2'd2
  } done_t;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] RP_SEND = 3'd1;
  localparam logic [2:0] RP_WAIT = 3'd2;
  localparam logic [2:0] RP_CAPT = 3'd3;
  localparam logic [2:0] RP_PROC = 3'd4;
  localparam logic [2:0] WP_SEND = 3'd1;
  localparam logic [2:0] WP_PROC = 3'd2;

  localparam logic [11:0] YearBase = 12'd2000;
  localparam logic [7:0]  Hundred  = 8'd100;

  // Chip register addresses are 0, 1, 2, 4, 5, 6 for slots 0 to 5.
  function automatic logic [2:0] reg_addr(input logic [2:0] idx);
    logic [2:0] res;
    if (idx < 3'd3) begin
      res = idx;
    end else begin
      res = idx + 3'd1;
    end
    return res;
  endfunction

  // Divide by ten through a reciprocal multiply, exact for 7-bit values.
  function automatic logic [7:0] bcd_encode(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  q;
    logic [6:0]  q10;
    logic [3:0]  r;
    prod = {8'd0, v} * 15'd205;
    q    = prod[14:11];
    q10  = {3'd0, q} * 7'd10;
    r    = 4'(v - q10);
    return {q, 4'd0} + {4'd0, r};
  endfunction

  function automatic logic [7:0] bcd_decode(input logic [7:0] b);
    logic [7:0] six_hi;
    six_hi = {4'd0, b[7:4]} * 8'd6;
    return b - six_hi;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rtc_bcd_time_i2c_sequencer_top.sv =====
// Top level of the RTC BCD time I2C sequencer: state registers, sequencing
// logic and the output register. Depends on rtcbcd_pkg.
//
// Usage: every input word on the in_ channel is one tick of the sequencer.
// Command 1 starts a read of the six time registers, command 2 latches the
// set_* time and starts a write, and any other command is a poll tick that
// advances the running transfer according to the controller flags in the
// same word. Each accepted word yields exactly one output word carrying the
// bus action to perform, its address and data bytes, and on completion the
// done code and, for a read, the decoded time.
// out_tvalid rises in the cycle after acceptance, and a new word can be
// accepted every cycle unless the output stalls, since the whole step is
// computed between the state registers and the output register. When the
// receiver stalls, the output register holds its word and in_tready drops
// until it is taken, so nothing is lost. Reset (rst_n low, synchronous)
// returns the sequencer to idle and empties the output register; the stored
// time slots are not cleared and are always written before they are read.
`default_nettype none

module rtc_bcd_time_i2c_sequencer_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // command[1:0], stop_pending[2], stop_detected[3], bus_busy[4],
  // rx_byte[12:5], set_second[18:13], set_minute[24:19], set_hour[29:25],
  // set_day[34:30], set_month[38:35], set_year[50:39], zeros[55:51]
  input  wire logic [rtcbcd_pkg::InDataW-1:0] in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // bus_action[2:0], address_byte[9:3], write_byte[17:10], done_res[19:18],
  // second[27:20], minute[35:28], hour[43:36], day[51:44], month[59:52],
  // year[71:60], hour_minute[86:72], month_day[101:87], zeros[103:102]
  output logic [rtcbcd_pkg::OutDataW-1:0]     out_tdata
);

  logic [1:0]  command;
  logic        stop_pending;
  logic        stop_detected;
  logic        bus_busy;
  logic [7:0]  rx_byte;
  logic [5:0]  set_second;
  logic [5:0]  set_minute;
  logic [4:0]  set_hour;
  logic [4:0]  set_day;
  logic [3:0]  set_month;
  logic [11:0] set_year;

  assign command       = in_tdata[1:0];
  assign stop_pending  = in_tdata[2];
  assign stop_detected = in_tdata[3];
  assign bus_busy      = in_tdata[4];
  assign rx_byte       = in_tdata[12:5];
  assign set_second    = in_tdata[18:13];
  assign set_minute    = in_tdata[24:19];
  assign set_hour      = in_tdata[29:25];
  assign set_day       = in_tdata[34:30];
  assign set_month     = in_tdata[38:35];
  assign set_year      = in_tdata[50:39];

  rtcbcd_pkg::mode_t mode_r, mode_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] step_r, step_nxt;
  logic [2:0] reg_addr_r, reg_addr_nxt;
  logic [7:0] captured_r, captured_nxt;
  logic [7:0] pend_byte_r, pend_byte_nxt;
  logic [7:0] slots_r [rtcbcd_pkg::NumRegs];
  logic [6:0] latched_r [rtcbcd_pkg::NumRegs];

  logic       slot_we;
  logic       latch_we;
  logic [6:0] year_ofs;
  logic [2:0] step_inc;
  logic [6:0] latched_next_val;

  rtcbcd_pkg::action_t action;
  rtcbcd_pkg::done_t   done;
  logic [6:0]  addr_byte;
  logic [7:0]  wbyte;
  logic [7:0]  o_sec, o_min, o_hour, o_day, o_mon;
  logic [11:0] o_year;
  logic [14:0] o_hm, o_md;
  logic [14:0] hour_x100, mon_x100;

  logic                              accept;
  logic                              out_valid_r;
  logic [rtcbcd_pkg::OutDataW-1:0]   out_data_r;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign year_ofs  = 7'(set_year - rtcbcd_pkg::YearBase);
  assign step_inc  = step_r + 3'd1;
  assign latched_next_val = (step_r < 3'd5) ? latched_r[step_inc] : 7'd0;
  assign hour_x100 = {7'd0, slots_r[2]} * {7'd0, rtcbcd_pkg::Hundred};
  assign mon_x100  = {7'd0, slots_r[4]} * {7'd0, rtcbcd_pkg::Hundred};

  always_comb begin
    mode_nxt      = mode_r;
    phase_nxt     = phase_r;
    step_nxt      = step_r;
    reg_addr_nxt  = reg_addr_r;
    captured_nxt  = captured_r;
    pend_byte_nxt = pend_byte_r;
    slot_we       = 1'b0;
    latch_we      = 1'b0;
    action        = rtcbcd_pkg::ACT_NONE;
    done          = rtcbcd_pkg::DONE_NONE;
    addr_byte     = 7'd0;
    wbyte         = 8'd0;
    o_sec         = 8'd0;
    o_min         = 8'd0;
    o_hour        = 8'd0;
    o_day         = 8'd0;
    o_mon         = 8'd0;
    o_year        = 12'd0;
    o_hm          = 15'd0;
    o_md          = 15'd0;
    if (command == rtcbcd_pkg::CMD_READ) begin
      mode_nxt     = rtcbcd_pkg::MODE_READ;
      phase_nxt    = rtcbcd_pkg::RP_SEND;
      step_nxt     = 3'd0;
      reg_addr_nxt = rtcbcd_pkg::reg_addr(3'd0);
    end else if (command == rtcbcd_pkg::CMD_WRITE) begin
      latch_we      = 1'b1;
      mode_nxt      = rtcbcd_pkg::MODE_WRITE;
      phase_nxt     = rtcbcd_pkg::WP_SEND;
      step_nxt      = 3'd0;
      reg_addr_nxt  = rtcbcd_pkg::reg_addr(3'd0);
      pend_byte_nxt = rtcbcd_pkg::bcd_encode({1'b0, set_second});
    end else if (mode_r == rtcbcd_pkg::MODE_READ) begin
      if (phase_r == rtcbcd_pkg::RP_SEND) begin
        action    = rtcbcd_pkg::ACT_ADDR;
        addr_byte = {reg_addr_r, 4'd0};
        phase_nxt = rtcbcd_pkg::RP_WAIT;
      end else if (phase_r == rtcbcd_pkg::RP_WAIT) begin
        if (!stop_pending) begin
          action    = rtcbcd_pkg::ACT_READ;
          phase_nxt = rtcbcd_pkg::RP_CAPT;
        end
      end else if (phase_r == rtcbcd_pkg::RP_CAPT) begin
        if (stop_detected) begin
          action       = rtcbcd_pkg::ACT_CLEAR;
          captured_nxt = rx_byte;
          phase_nxt    = rtcbcd_pkg::RP_PROC;
        end
      end else if (step_r < 3'd6) begin
        slot_we = 1'b1;
        if (step_r < 3'd5) begin
          reg_addr_nxt = rtcbcd_pkg::reg_addr(step_inc);
          phase_nxt    = rtcbcd_pkg::RP_SEND;
        end
        step_nxt = step_inc;
      end else if (step_r == 3'd6) begin
        step_nxt = 3'd7;
      end else begin
        done      = rtcbcd_pkg::DONE_READ;
        o_sec     = slots_r[0];
        o_min     = slots_r[1];
        o_hour    = slots_r[2];
        o_day     = slots_r[3];
        o_mon     = slots_r[4];
        o_year    = {4'd0, slots_r[5]} + rtcbcd_pkg::YearBase;
        o_hm      = hour_x100 + {7'd0, slots_r[1]};
        o_md      = mon_x100 + {7'd0, slots_r[3]};
        mode_nxt  = rtcbcd_pkg::MODE_IDLE;
        phase_nxt = rtcbcd_pkg::PH_IDLE;
        step_nxt  = 3'd0;
      end
    end else if (mode_r == rtcbcd_pkg::MODE_WRITE) begin
      if (phase_r == rtcbcd_pkg::WP_SEND) begin
        if (!stop_pending && !bus_busy) begin
          action    = rtcbcd_pkg::ACT_WDATA;
          addr_byte = {reg_addr_r, 4'd0};
          wbyte     = pend_byte_r;
          phase_nxt = rtcbcd_pkg::WP_PROC;
        end
      end else if (step_r < 3'd5) begin
        step_nxt      = step_inc;
        reg_addr_nxt  = rtcbcd_pkg::reg_addr(step_inc);
        pend_byte_nxt = rtcbcd_pkg::bcd_encode(latched_next_val);
        phase_nxt     = rtcbcd_pkg::WP_SEND;
      end else begin
        done      = rtcbcd_pkg::DONE_WRITE;
        mode_nxt  = rtcbcd_pkg::MODE_IDLE;
        phase_nxt = rtcbcd_pkg::PH_IDLE;
        step_nxt  = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= rtcbcd_pkg::MODE_IDLE;
      phase_r     <= rtcbcd_pkg::PH_IDLE;
      step_r      <= 3'd0;
      reg_addr_r  <= 3'd0;
      captured_r  <= 8'd0;
      pend_byte_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r      <= mode_nxt;
        phase_r     <= phase_nxt;
        step_r      <= step_nxt;
        reg_addr_r  <= reg_addr_nxt;
        captured_r  <= captured_nxt;
        pend_byte_r <= pend_byte_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && slot_we) begin
      slots_r[step_r] <= rtcbcd_pkg::bcd_decode(captured_r);
    end
    if (accept && latch_we) begin
      latched_r[0] <= {1'b0, set_second};
      latched_r[1] <= {1'b0, set_minute};
      latched_r[2] <= {2'b0, set_hour};
      latched_r[3] <= {2'b0, set_day};
      latched_r[4] <= {3'b0, set_month};
      latched_r[5] <= year_ofs;
    end
    if (accept) begin
      out_data_r <= {2'd0, o_md, o_hm, o_year, o_mon, o_day, o_hour, o_min, o_sec,
                     done, wbyte, addr_byte, action};
    end
  end

endmodule

`default_nettype wire

// ===== bench/rtc_time_checker.sv =====
`timescale 1ns / 1ps
// Checker for the RTC BCD time I2C sequencer: watches the in_ and out_ streams,
// predicts every result word from its own model of the sequencer and compares.
// Depends on rtcbcd_pkg; instantiated by tb_top.
module rtc_time_checker
  import rtcbcd_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  output int                  fail_count,
  output int                  pending_words,
  output int                  words_checked,
  output int                  reads_done,
  output int                  writes_done
);

  typedef struct packed {
    logic [4:0]  pad;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
    logic [7:0]  rx_byte;
    logic        bus_busy;
    logic        stop_detected;
    logic        stop_pending;
    cmd_t        command;
  } tick_t;

  typedef struct packed {
    logic [1:0]  pad;
    logic [14:0] month_day;
    logic [14:0] hour_minute;
    logic [11:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    done_t       done_res;
    logic [7:0]  write_byte;
    logic [6:0]  address_byte;
    action_t     bus_action;
  } result_t;

  // Chip register address of each time slot, slot 0 in the lowest bits.
  localparam logic [17:0] SlotAddrs = {3'd6, 3'd5, 3'd4, 3'd2, 3'd1, 3'd0};

  mode_t      seq_mode;
  logic [2:0] seq_phase;
  logic [2:0] seq_step;
  logic [2:0] seq_reg;
  logic [7:0] rx_hold;
  logic [7:0] wr_hold;
  logic [7:0] time_slots [6];
  logic [6:0] set_latch [6];
  result_t    expected_words [$];

  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    int tens;
    tens = v / 10;
    return 8'((tens << 4) + (v % 10));
  endfunction

  function automatic logic [7:0] from_bcd(input logic [7:0] b);
    return 8'(int'(b) - 6 * int'(b[7:4]));
  endfunction

  function automatic void sequencer_to_idle();
    seq_mode  = MODE_IDLE;
    seq_phase = PH_IDLE;
    seq_step  = 3'd0;
  endfunction

  function automatic result_t advance_sequencer(input tick_t t);
    result_t r;
    r = '0;
    if (t.command == CMD_READ) begin
      seq_mode  = MODE_READ;
      seq_phase = RP_SEND;
      seq_step  = 3'd0;
      seq_reg   = SlotAddrs[2:0];
    end else if (t.command == CMD_WRITE) begin
      set_latch[0] = 7'(t.set_second);
      set_latch[1] = 7'(t.set_minute);
      set_latch[2] = 7'(t.set_hour);
      set_latch[3] = 7'(t.set_day);
      set_latch[4] = 7'(t.set_month);
      set_latch[5] = 7'(t.set_year - YearBase);
      seq_mode  = MODE_WRITE;
      seq_phase = WP_SEND;
      seq_step  = 3'd0;
      seq_reg   = SlotAddrs[2:0];
      wr_hold   = to_bcd(set_latch[0]);
    end else if (seq_mode == MODE_READ) begin
      case (seq_phase)
        RP_SEND: begin
          r.bus_action   = ACT_ADDR;
          r.address_byte = {seq_reg, 4'd0};
          seq_phase      = RP_WAIT;
        end
        RP_WAIT: begin
          if (!t.stop_pending) begin
            r.bus_action = ACT_READ;
            seq_phase    = RP_CAPT;
          end
        end
        RP_CAPT: begin
          if (t.stop_detected) begin
            r.bus_action = ACT_CLEAR;
            rx_hold      = t.rx_byte;
            seq_phase    = RP_PROC;
          end
        end
        default: begin
          if (seq_step < 3'd6) begin
            time_slots[seq_step] = from_bcd(rx_hold);
            if (seq_step < 3'd5) begin
              seq_reg   = SlotAddrs[(seq_step + 1) * 3 +: 3];
              seq_phase = RP_SEND;
            end
            seq_step = seq_step + 3'd1;
          end else if (seq_step == 3'd6) begin
            seq_step = 3'd7;
          end else begin
            r.done_res    = DONE_READ;
            r.second      = time_slots[0];
            r.minute      = time_slots[1];
            r.hour        = time_slots[2];
            r.day         = time_slots[3];
            r.month       = time_slots[4];
            r.year        = 12'(time_slots[5] + YearBase);
            r.hour_minute = 15'(time_slots[2] * 100 + time_slots[1]);
            r.month_day   = 15'(time_slots[4] * 100 + time_slots[3]);
            sequencer_to_idle();
          end
        end
      endcase
    end else if (seq_mode == MODE_WRITE) begin
      if (seq_phase == WP_SEND) begin
        if (!t.stop_pending && !t.bus_busy) begin
          r.bus_action   = ACT_WDATA;
          r.address_byte = {seq_reg, 4'd0};
          r.write_byte   = wr_hold;
          seq_phase      = WP_PROC;
        end
      end else if (seq_step < 3'd5) begin
        seq_step  = seq_step + 3'd1;
        seq_reg   = SlotAddrs[seq_step * 3 +: 3];
        wr_hold   = to_bcd(set_latch[seq_step]);
        seq_phase = WP_SEND;
      end else begin
        r.done_res = DONE_WRITE;
        sequencer_to_idle();
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      sequencer_to_idle();
      seq_reg = 3'd0;
      rx_hold = 8'd0;
      wr_hold = 8'd0;
      for (int i = 0; i < NumRegs; i++) begin
        time_slots[i] = 8'd0;
        set_latch[i]  = 7'd0;
      end
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("Result word arrived with no expected word waiting");
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          got  = result_t'(out_tdata);
          check_field("bus_action", 16'(want.bus_action), 16'(got.bus_action));
          check_field("address_byte", 16'(want.address_byte), 16'(got.address_byte));
          check_field("write_byte", 16'(want.write_byte), 16'(got.write_byte));
          check_field("done_res", 16'(want.done_res), 16'(got.done_res));
          check_field("second", 16'(want.second), 16'(got.second));
          check_field("minute", 16'(want.minute), 16'(got.minute));
          check_field("hour", 16'(want.hour), 16'(got.hour));
          check_field("day", 16'(want.day), 16'(got.day));
          check_field("month", 16'(want.month), 16'(got.month));
          check_field("year", 16'(want.year), 16'(got.year));
          check_field("hour_minute", 16'(want.hour_minute), 16'(got.hour_minute));
          check_field("month_day", 16'(want.month_day), 16'(got.month_day));
          words_checked++;
          if (want.done_res == DONE_READ) begin
            reads_done++;
          end else if (want.done_res == DONE_WRITE) begin
            writes_done++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_words.push_back(advance_sequencer(tick_t'(in_tdata)));
      end
    end
    pending_words = expected_words.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the testbench for the RTC BCD time I2C sequencer: clock, reset,
// stimulus and verdict. Depends on rtcbcd_pkg, the sequencer and rtc_time_checker.
module tb_top;
  import rtcbcd_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int PhaseWords  = 200;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic [InDataW-1:0]  in_tdata   = '0;
  logic                out_tready = 1'b0;
  logic                in_tready;
  logic                out_tvalid;
  logic [OutDataW-1:0] out_tdata;

  int fail_count;
  int pending_words;
  int words_checked;
  int reads_done;
  int writes_done;
  int words_sent;
  int cycle_count;
  int send_idle_pct;
  int stall_pct;

  rtc_bcd_time_i2c_sequencer_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  rtc_time_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked),
    .reads_done    (reads_done),
    .writes_done   (writes_done)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [InDataW-1:0] pack_tick(
    input cmd_t c, input logic sp, input logic sd, input logic bb,
    input logic [7:0] rx, input logic [5:0] s, input logic [5:0] mi,
    input logic [4:0] h, input logic [4:0] d, input logic [3:0] mo,
    input logic [11:0] y);
    return {5'd0, y, mo, d, h, mi, s, rx, bb, sd, sp, c};
  endfunction

  function automatic logic [InDataW-1:0] random_tick(input cmd_t c);
    logic [7:0] rx;
    int         pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      rx = 8'hFF;
    end else if (pick == 1) begin
      rx = 8'h00;
    end else if (pick < 5) begin
      rx = 8'($urandom_range(255));
    end else begin
      rx = {4'($urandom_range(9)), 4'($urandom_range(9))};
    end
    if ($urandom_range(4) == 0) begin
      return pack_tick(c, $urandom_range(99) < 30, $urandom_range(99) < 70,
                       $urandom_range(99) < 25, rx,
                       6'($urandom_range(63)), 6'($urandom_range(63)),
                       5'($urandom_range(31)), 5'($urandom_range(31)),
                       4'($urandom_range(15)), 12'($urandom_range(4095)));
    end
    return pack_tick(c, $urandom_range(99) < 30, $urandom_range(99) < 70,
                     $urandom_range(99) < 25, rx,
                     6'($urandom_range(59)), 6'($urandom_range(59)),
                     5'($urandom_range(23)), 5'($urandom_range(31, 1)),
                     4'($urandom_range(12, 1)), 12'($urandom_range(2099, 2000)));
  endfunction

  task automatic send_tick(input logic [InDataW-1:0] word);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < 30 && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // A start word followed by poll words with random controller flags; short
  // runs leave the transfer unfinished for the next start to cut off.
  task automatic run_transfer(input cmd_t start);
    int polls;
    send_tick(random_tick(start));
    polls = (start == CMD_READ) ? $urandom_range(48, 20) : $urandom_range(32, 10);
    repeat (polls) begin
      send_tick(random_tick(($urandom_range(9) == 0) ? CMD_SPARE : CMD_POLL));
    end
  endtask

  initial begin
    int pick;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_tick(pack_tick(CMD_POLL, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    send_tick(pack_tick(CMD_SPARE, 1'b1, 1'b1, 1'b1, 8'hFF, 6'd63, 6'd63, 5'd31, 5'd31,
                        4'd15, 12'd4095));
    send_tick(pack_tick(CMD_READ, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    send_tick(pack_tick(CMD_POLL, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    send_tick(pack_tick(CMD_WRITE, 1'b0, 1'b0, 1'b0, 8'h00, 6'd59, 6'd59, 5'd23, 5'd31,
                        4'd12, 12'd2099));
    send_tick(pack_tick(CMD_POLL, 1'b0, 1'b0, 1'b1, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    send_tick(pack_tick(CMD_POLL, 1'b1, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    repeat (12) send_tick(pack_tick(CMD_POLL, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0,
                                    5'd0, 5'd0, 4'd0, 12'd0));
    send_tick(pack_tick(CMD_WRITE, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd1,
                        4'd1, 12'd2000));
    send_tick(pack_tick(CMD_WRITE, 1'b0, 1'b0, 1'b0, 8'h00, 6'd63, 6'd63, 5'd31, 5'd31,
                        4'd15, 12'd4095));
    send_tick(pack_tick(CMD_POLL, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    send_tick(pack_tick(CMD_READ, 1'b0, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    send_tick(pack_tick(CMD_POLL, 1'b1, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));
    send_tick(pack_tick(CMD_POLL, 1'b1, 1'b0, 1'b0, 8'h00, 6'd0, 6'd0, 5'd0, 5'd0,
                        4'd0, 12'd0));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 54;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 54;
        end
        default: begin
          send_idle_pct = 8;
          stall_pct     = 8;
        end
      endcase
      while (words_sent < (phase + 1) * PhaseWords + 25) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          run_transfer(CMD_READ);
        end else if (pick < 85) begin
          run_transfer(CMD_WRITE);
        end else begin
          repeat ($urandom_range(8, 1)) send_tick(random_tick(cmd_t'($urandom_range(3))));
        end
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("Sent %0d input words over four pacing mixes; checked %0d result words.",
             words_sent, words_checked);
    $display("The run completed %0d time reads and %0d time writes.",
             reads_done, writes_done);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== rtc_bcd_time_i2c_sequencer_top.f =====
rtl/rtcbcd_pkg.sv
rtl/rtc_bcd_time_i2c_sequencer_top.sv
bench/rtc_time_checker.sv
bench/tb_top.sv
